@@ rtl/isa_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// isa_pkg - shared types and constants for the IMU sample averager
// Field widths, opcodes, register indexes, sequencer states, saturation.
// ============================================================================
package isa_pkg;

    localparam int ISA_MAX_COUNT = 19;

    localparam int RAW_W   = 16;   // raw sample / offset width
    localparam int GAIN_W  = 32;   // Q8.24 gain
    localparam int ALPHA_W = 17;   // Q0.16 alpha, 65536 = unity
    localparam int RES_W   = 32;   // Q15.16 result
    localparam int OP_W    = 2;
    localparam int IDX_W   = 3;
    localparam int DATA_W  = 32;

    localparam logic [ALPHA_W-1:0] UNITY_ALPHA = ALPHA_W'(65536);
    localparam logic [GAIN_W-1:0]  UNITY_GAIN  = GAIN_W'(16777216);

    typedef enum logic [OP_W-1:0] {
        OP_SAMPLE    = 2'd0,
        OP_FIN_GYRO  = 2'd1,
        OP_FIN_ACCEL = 2'd2,
        OP_NOP       = 2'd3
    } t_opcode;

    typedef enum logic [IDX_W-1:0] {
        REG_GYRO_OFFSET    = 3'd0,
        REG_ACCEL_Y_OFFSET = 3'd1,
        REG_ACCEL_Z_OFFSET = 3'd2,
        REG_GYRO_GAIN      = 3'd3,
        REG_ACCEL_Y_GAIN   = 3'd4,
        REG_ACCEL_Z_GAIN   = 3'd5,
        REG_GYRO_ALPHA     = 3'd6,
        REG_UNUSED         = 3'd7
    } t_reg_idx;

    typedef enum logic {
        RK_GYRO  = 1'b0,
        RK_ACCEL = 1'b1
    } t_result_kind;

    typedef enum logic [1:0] {
        CH_GYRO = 2'd0,
        CH_AY   = 2'd1,
        CH_AZ   = 2'd2
    } t_chan;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV,
        ST_DIFF,
        ST_MLO,
        ST_MHI,
        ST_ACC,
        ST_SCL,
        ST_FMUL,
        ST_FADD,
        ST_DONE
    } t_state;

    // clamp a wide signed value to signed 32 bits
    function automatic logic signed [RES_W-1:0] sat32(input logic signed [63:0] v);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = 64'sd2147483647;
        lo = -64'sd2147483648;
        if (v > hi) begin
            sat32 = 32'sh7FFF_FFFF;
        end else if (v < lo) begin
            sat32 = 32'sh8000_0000;
        end else begin
            sat32 = v[RES_W-1:0];
        end
    endfunction

endpackage
`default_nettype wire

@@ rtl/isa_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// isa_if - channel interfaces for the IMU sample averager
// Sample/finish input, result output and register write channels.
// ============================================================================
interface isa_in_if import isa_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [OP_W-1:0]          opcode;
    logic signed [RAW_W-1:0]  gyro_x_raw;
    logic signed [RAW_W-1:0]  accel_y_raw;
    logic signed [RAW_W-1:0]  accel_z_raw;

    modport source (output valid, opcode, gyro_x_raw, accel_y_raw, accel_z_raw,
                    input ready);
    modport sink   (input valid, opcode, gyro_x_raw, accel_y_raw, accel_z_raw,
                    output ready);
endinterface

interface isa_out_if import isa_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic                     result_kind;
    logic signed [RES_W-1:0]  gyro_rate;
    logic signed [RES_W-1:0]  accel_y_value;
    logic signed [RES_W-1:0]  accel_z_value;

    modport source (output valid, result_kind, gyro_rate, accel_y_value, accel_z_value,
                    input ready);
    modport sink   (input valid, result_kind, gyro_rate, accel_y_value, accel_z_value,
                    output ready);
endinterface

interface isa_cfg_if import isa_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [IDX_W-1:0]   index;
    logic [DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ rtl/imu_sample_averager.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// imu_sample_averager - boxcar average, scale and IIR smooth of IMU channels
// Sums gyro-x / accel-y / accel-z samples, and on a finish transfer turns the
// batch mean into a saturated Q15.16 value; gyro also gets a Q0.16 IIR.
// ============================================================================
//
//  Channel   Dir  Modport  Payload
//  i_in      in   sink     opcode, gyro_x_raw, accel_y_raw, accel_z_raw
//  o_out     out  source   result_kind, gyro_rate, accel_y_value, accel_z_value
//  i_cfg     in   sink     index (register number), data
//
//  Sample transfers are accepted back to back while idle.
//  A finish runs the one-bit-per-cycle restoring divider over a DW-bit dividend,
//  DW = 24 + clog2(MAX_COUNT+1) (29 at MAX_COUNT = 19), then the shared 34x18
//  multiplier; gyro adds the IIR step, accel repeats the sequence for z.
//  i_in.ready is low from a finish transfer until its result is loaded into
//  the output register; a held result stalls only the next finish.
//  Reset (synchronous, active low) clears sums, counts, first samples, the
//  filter state and the registers to their defaults. i_cfg is always ready.
//
module imu_sample_averager import isa_pkg::*; #(
    parameter int MAX_COUNT = ISA_MAX_COUNT
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    isa_in_if.sink      i_in,
    isa_out_if.source   o_out,
    isa_cfg_if.sink     i_cfg
);

    // ------------------------------------------------------------------
    // derived widths
    // ------------------------------------------------------------------
    localparam int CW   = $clog2(MAX_COUNT + 1);   // sample count
    localparam int SW   = RAW_W + CW;              // running sum
    localparam int DW   = SW + 8;                  // dividend: |sum| * 256
    localparam int STW  = $clog2(DW);              // divider step counter
    localparam int QW   = 25;                      // |mean| in Q.8 <= 2^23
    localparam int DFW  = 27;                      // mean - offset*256
    localparam int MAW  = 34;                      // multiplier operand A
    localparam int MBW  = 18;                      // multiplier operand B
    localparam int MPW  = MAW + MBW;               // multiplier product
    localparam int ACCW = 60;                      // full d * gain product
    localparam int HALF = GAIN_W / 2;

    localparam logic [CW-1:0]  CNT_MAX  = CW'(MAX_COUNT);
    localparam logic [STW-1:0] STEP_END = STW'(DW - 1);

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    t_state r_state, n_state;
    t_chan  r_ch, n_ch;

    // configuration
    logic signed [RAW_W-1:0] r_off_g, r_off_y, r_off_z;
    logic [GAIN_W-1:0]       r_gain_g, r_gain_y, r_gain_z;
    logic [ALPHA_W-1:0]      r_alpha;

    // batch state
    logic signed [SW-1:0]    r_sum_g, r_sum_y, r_sum_z;
    logic signed [SW-1:0]    n_sum_g, n_sum_y, n_sum_z;
    logic [CW-1:0]           r_cnt_g, r_cnt_a, n_cnt_g, n_cnt_a;
    logic signed [RAW_W-1:0] r_first_g, r_first_y, r_first_z;
    logic signed [RAW_W-1:0] n_first_g, n_first_y, n_first_z;
    logic signed [RES_W-1:0] r_prev, n_prev;

    // datapath
    logic [STW-1:0]          r_step, n_step;
    logic [CW-1:0]           r_rem, n_rem;
    logic [DW-1:0]           r_quo, n_quo;
    logic signed [DFW-1:0]   r_d, n_d;
    logic signed [MPW-1:0]   r_prod, n_prod;
    logic signed [ACCW-1:0]  r_acc, n_acc;
    logic signed [RES_W-1:0] r_res_g, r_res_y, r_res_z;
    logic signed [RES_W-1:0] n_res_g, n_res_y, n_res_z;

    // output register
    logic                    r_o_valid, n_o_valid;
    logic                    r_o_kind, n_o_kind;
    logic signed [RES_W-1:0] r_o_g, r_o_y, r_o_z, n_o_g, n_o_y, n_o_z;

    // ------------------------------------------------------------------
    // handshakes
    // ------------------------------------------------------------------
    logic in_xfer, out_xfer, cfg_xfer;

    assign i_in.ready  = (r_state == ST_IDLE);
    assign i_cfg.ready = 1'b1;
    assign in_xfer     = i_in.valid && i_in.ready;
    assign out_xfer    = o_out.valid && o_out.ready;
    assign cfg_xfer    = i_cfg.valid && i_cfg.ready;

    assign o_out.valid         = r_o_valid;
    assign o_out.result_kind   = r_o_kind;
    assign o_out.gyro_rate     = r_o_g;
    assign o_out.accel_y_value = r_o_y;
    assign o_out.accel_z_value = r_o_z;

    // ------------------------------------------------------------------
    // per-channel selection for the shared datapath
    // ------------------------------------------------------------------
    logic signed [SW-1:0]    sel_sum;
    logic [CW-1:0]           sel_cnt;
    logic signed [RAW_W-1:0] sel_first;
    logic signed [RAW_W-1:0] sel_off;
    logic [GAIN_W-1:0]       sel_gain;

    always_comb begin
        case (r_ch)
            CH_GYRO: begin
                sel_sum   = r_sum_g;
                sel_cnt   = r_cnt_g;
                sel_first = r_first_g;
                sel_off   = r_off_g;
                sel_gain  = r_gain_g;
            end
            CH_AY: begin
                sel_sum   = r_sum_y;
                sel_cnt   = r_cnt_a;
                sel_first = r_first_y;
                sel_off   = r_off_y;
                sel_gain  = r_gain_y;
            end
            default: begin
                sel_sum   = r_sum_z;
                sel_cnt   = r_cnt_a;
                sel_first = r_first_z;
                sel_off   = r_off_z;
                sel_gain  = r_gain_z;
            end
        endcase
    end

    // magnitudes of the sums, as divider dividends (|min| still fits SW bits)
    logic [SW-1:0] mag_g, mag_y, mag_z;
    assign mag_g = r_sum_g[SW-1] ? SW'(-r_sum_g) : SW'(r_sum_g);
    assign mag_y = r_sum_y[SW-1] ? SW'(-r_sum_y) : SW'(r_sum_y);
    assign mag_z = r_sum_z[SW-1] ? SW'(-r_sum_z) : SW'(r_sum_z);

    // alpha above unity behaves as unity
    logic [ALPHA_W-1:0] alpha_c;
    assign alpha_c = (r_alpha > UNITY_ALPHA) ? UNITY_ALPHA : r_alpha;

    // ------------------------------------------------------------------
    // shared multiplier: d * gain halves, then (new - prev) * alpha
    // ------------------------------------------------------------------
    logic signed [MAW-1:0] mul_a;
    logic signed [MBW-1:0] mul_b;
    logic signed [MPW-1:0] mul_p;

    always_comb begin
        case (r_state)
            ST_MHI: begin
                mul_a = MAW'(r_d);
                mul_b = $signed({2'b00, sel_gain[GAIN_W-1:HALF]});
            end
            ST_FMUL: begin
                mul_a = MAW'(r_res_g) - MAW'(r_prev);
                mul_b = $signed({1'b0, alpha_c});
            end
            default: begin
                mul_a = MAW'(r_d);
                mul_b = $signed({2'b00, sel_gain[HALF-1:0]});
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // ------------------------------------------------------------------
    // divider step: restoring, one quotient bit per cycle
    // ------------------------------------------------------------------
    logic [CW:0]   div_shf;
    logic          div_bit;
    logic [CW-1:0] div_rem;

    assign div_shf = {r_rem, r_quo[DW-1]};
    assign div_bit = (div_shf >= {1'b0, sel_cnt});
    assign div_rem = div_bit ? CW'(div_shf - {1'b0, sel_cnt}) : div_shf[CW-1:0];

    // mean in Q.8 (truncated toward zero), then offset removal
    logic signed [DFW-1:0] mean_q8;
    logic signed [DFW-1:0] mag_q;

    assign mag_q = $signed({{(DFW-QW){1'b0}}, r_quo[QW-1:0]});

    always_comb begin
        if (sel_cnt == '0) begin
            mean_q8 = DFW'(sel_first) <<< 8;
        end else if (sel_sum[SW-1]) begin
            mean_q8 = -mag_q;
        end else begin
            mean_q8 = mag_q;
        end
    end

    // ------------------------------------------------------------------
    // sequencer and datapath next values
    // ------------------------------------------------------------------
    logic signed [RAW_W-1:0] in_gx, in_ay, in_az;
    assign in_gx = i_in.gyro_x_raw;
    assign in_ay = i_in.accel_y_raw;
    assign in_az = i_in.accel_z_raw;

    always_comb begin
        n_state   = r_state;
        n_ch      = r_ch;
        n_sum_g   = r_sum_g;
        n_sum_y   = r_sum_y;
        n_sum_z   = r_sum_z;
        n_cnt_g   = r_cnt_g;
        n_cnt_a   = r_cnt_a;
        n_first_g = r_first_g;
        n_first_y = r_first_y;
        n_first_z = r_first_z;
        n_prev    = r_prev;
        n_step    = r_step;
        n_rem     = r_rem;
        n_quo     = r_quo;
        n_d       = r_d;
        n_prod    = r_prod;
        n_acc     = r_acc;
        n_res_g   = r_res_g;
        n_res_y   = r_res_y;
        n_res_z   = r_res_z;
        n_o_valid = r_o_valid && !out_xfer;
        n_o_kind  = r_o_kind;
        n_o_g     = r_o_g;
        n_o_y     = r_o_y;
        n_o_z     = r_o_z;

        case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    case (t_opcode'(i_in.opcode))
                        OP_SAMPLE: begin
                            // saturated groups drop the sample
                            if (r_cnt_g < CNT_MAX) begin
                                if (r_cnt_g == '0) n_first_g = in_gx;
                                n_sum_g = r_sum_g + SW'(in_gx);
                                n_cnt_g = r_cnt_g + 1'b1;
                            end
                            if (r_cnt_a < CNT_MAX) begin
                                if (r_cnt_a == '0) begin
                                    n_first_y = in_ay;
                                    n_first_z = in_az;
                                end
                                n_sum_y = r_sum_y + SW'(in_ay);
                                n_sum_z = r_sum_z + SW'(in_az);
                                n_cnt_a = r_cnt_a + 1'b1;
                            end
                        end
                        OP_FIN_GYRO: begin
                            n_ch    = CH_GYRO;
                            n_quo   = {mag_g, 8'h00};
                            n_rem   = '0;
                            n_step  = '0;
                            n_state = (r_cnt_g == '0) ? ST_DIFF : ST_DIV;
                        end
                        OP_FIN_ACCEL: begin
                            n_ch    = CH_AY;
                            n_quo   = {mag_y, 8'h00};
                            n_rem   = '0;
                            n_step  = '0;
                            n_state = (r_cnt_a == '0) ? ST_DIFF : ST_DIV;
                        end
                        default: begin
                        end
                    endcase
                end
            end

            ST_DIV: begin
                n_rem  = div_rem;
                n_quo  = {r_quo[DW-2:0], div_bit};
                n_step = r_step + 1'b1;
                if (r_step == STEP_END) n_state = ST_DIFF;
            end

            ST_DIFF: begin
                n_d     = mean_q8 - (DFW'(sel_off) <<< 8);
                n_state = ST_MLO;
            end

            ST_MLO: begin
                n_prod  = mul_p;
                n_state = ST_MHI;
            end

            ST_MHI: begin
                n_acc   = ACCW'(r_prod);
                n_prod  = mul_p;
                n_state = ST_ACC;
            end

            ST_ACC: begin
                n_acc   = r_acc + (ACCW'(r_prod) <<< HALF);
                n_state = ST_SCL;
            end

            ST_SCL: begin
                case (r_ch)
                    CH_GYRO: begin
                        n_res_g = sat32(64'(r_acc >>> 16));
                        // empty batch: unfiltered, filter state kept
                        n_state = (r_cnt_g == '0) ? ST_DONE : ST_FMUL;
                    end
                    CH_AY: begin
                        n_res_y = sat32(64'(r_acc >>> 16));
                        n_ch    = CH_AZ;
                        n_quo   = {mag_z, 8'h00};
                        n_rem   = '0;
                        n_step  = '0;
                        n_state = (r_cnt_a == '0) ? ST_DIFF : ST_DIV;
                    end
                    default: begin
                        n_res_z = sat32(64'(r_acc >>> 16));
                        n_state = ST_DONE;
                    end
                endcase
            end

            ST_FMUL: begin
                n_prod  = mul_p;
                n_state = ST_FADD;
            end

            ST_FADD: begin
                // y = prev + floor(alpha * (x - prev) / 2^16)
                n_res_g = sat32(64'(r_prev) + 64'(r_prod >>> 16));
                n_prev  = sat32(64'(r_prev) + 64'(r_prod >>> 16));
                n_state = ST_DONE;
            end

            ST_DONE: begin
                if (!r_o_valid || o_out.ready) begin
                    n_o_valid = 1'b1;
                    if (r_ch == CH_GYRO) begin
                        n_o_kind = RK_GYRO;
                        n_o_g    = r_res_g;
                        n_o_y    = '0;
                        n_o_z    = '0;
                        n_sum_g  = '0;
                        n_cnt_g  = '0;
                    end else begin
                        n_o_kind = RK_ACCEL;
                        n_o_g    = '0;
                        n_o_y    = r_res_y;
                        n_o_z    = r_res_z;
                        n_sum_y  = '0;
                        n_sum_z  = '0;
                        n_cnt_a  = '0;
                    end
                    n_state = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // state and control registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_ch      <= CH_GYRO;
            r_sum_g   <= '0;
            r_sum_y   <= '0;
            r_sum_z   <= '0;
            r_cnt_g   <= '0;
            r_cnt_a   <= '0;
            r_first_g <= '0;
            r_first_y <= '0;
            r_first_z <= '0;
            r_prev    <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_ch      <= n_ch;
            r_sum_g   <= n_sum_g;
            r_sum_y   <= n_sum_y;
            r_sum_z   <= n_sum_z;
            r_cnt_g   <= n_cnt_g;
            r_cnt_a   <= n_cnt_a;
            r_first_g <= n_first_g;
            r_first_y <= n_first_y;
            r_first_z <= n_first_z;
            r_prev    <= n_prev;
            r_o_valid <= n_o_valid;
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        r_step  <= n_step;
        r_rem   <= n_rem;
        r_quo   <= n_quo;
        r_d     <= n_d;
        r_prod  <= n_prod;
        r_acc   <= n_acc;
        r_res_g <= n_res_g;
        r_res_y <= n_res_y;
        r_res_z <= n_res_z;
        r_o_kind <= n_o_kind;
        r_o_g   <= n_o_g;
        r_o_y   <= n_o_y;
        r_o_z   <= n_o_z;
    end

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off_g  <= '0;
            r_off_y  <= '0;
            r_off_z  <= '0;
            r_gain_g <= UNITY_GAIN;
            r_gain_y <= UNITY_GAIN;
            r_gain_z <= UNITY_GAIN;
            r_alpha  <= UNITY_ALPHA;
        end else if (cfg_xfer) begin
            case (t_reg_idx'(i_cfg.index))
                REG_GYRO_OFFSET:    r_off_g  <= $signed(i_cfg.data[RAW_W-1:0]);
                REG_ACCEL_Y_OFFSET: r_off_y  <= $signed(i_cfg.data[RAW_W-1:0]);
                REG_ACCEL_Z_OFFSET: r_off_z  <= $signed(i_cfg.data[RAW_W-1:0]);
                REG_GYRO_GAIN:      r_gain_g <= i_cfg.data[GAIN_W-1:0];
                REG_ACCEL_Y_GAIN:   r_gain_y <= i_cfg.data[GAIN_W-1:0];
                REG_ACCEL_Z_GAIN:   r_gain_z <= i_cfg.data[GAIN_W-1:0];
                REG_GYRO_ALPHA:     r_alpha  <= i_cfg.data[ALPHA_W-1:0];
                default: begin
                end
            endcase
        end
    end

endmodule
`default_nettype wire

@@ rtl/isa_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// isa_port_checker - port-level checks for the IMU sample averager
// Result shape and finish/result sequencing as seen on the channels.
// ============================================================================
module isa_port_checker import isa_pkg::*; (
    input wire                    i_clk,
    input wire                    i_rst_n,
    input wire                    i_in_valid,
    input wire                    i_in_ready,
    input wire [OP_W-1:0]         i_in_opcode,
    input wire                    i_out_valid,
    input wire                    i_out_ready,
    input wire                    i_out_kind,
    input wire signed [RES_W-1:0] i_out_gyro,
    input wire signed [RES_W-1:0] i_out_ay,
    input wire signed [RES_W-1:0] i_out_az
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_kind)
            && $stable(i_out_gyro) && $stable(i_out_ay) && $stable(i_out_az))
        else $error("result changed while stalled");

    a_gyro_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_kind == RK_GYRO |-> i_out_ay == '0 && i_out_az == '0)
        else $error("gyro result carries accel values");

    a_accel_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_kind == RK_ACCEL |-> i_out_gyro == '0)
        else $error("accel result carries a gyro value");

    // a finish transfer occupies the sequencer
    a_finish_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready
            && (i_in_opcode == OP_FIN_GYRO || i_in_opcode == OP_FIN_ACCEL)
            |=> !i_in_ready)
        else $error("input ready right after a finish transfer");

    // a new result only appears at the end of a busy period
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> !$past(i_in_ready))
        else $error("result appeared without a finish in progress");

endmodule

bind imu_sample_averager isa_port_checker u_isa_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_opcode (i_in.opcode),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_kind  (o_out.result_kind),
    .i_out_gyro  (o_out.gyro_rate),
    .i_out_ay    (o_out.accel_y_value),
    .i_out_az    (o_out.accel_z_value)
);
`default_nettype wire
